### design/lprd_pkg.sv
// ----------------------------------------------------------------------------
// lprd_pkg
// Types and constants for the length-prefixed request deframer.
// ----------------------------------------------------------------------------
package lprd_pkg;

    localparam int unsigned FIELD_W    = 32;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [FIELD_W-1:0] MAX_FRAME_BYTES_RST  = 32'd33554432;
    localparam logic [FIELD_W-1:0] MAX_STRING_COUNT_RST = 32'd200000;

    // phase of the deframer, also used as the byte role tag
    typedef enum logic [2:0] {
        PH_FLEN    = 3'd0,
        PH_COUNT   = 3'd1,
        PH_SLEN    = 3'd2,
        PH_DATA    = 3'd3,
        PH_DISCARD = 3'd4,
        PH_CLOSED  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_ACCEPT   = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_BAD      = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_FRAME_BYTES  = 1'b0,
        CFG_MAX_STRING_COUNT = 1'b1
    } t_cfg_idx;

    localparam logic [1:0] POS_LAST = 2'd3;

endpackage

### design/length_prefixed_request_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer
// Tags each byte of a length-prefixed request stream with its role, string
// index and end marks, and reports frame acceptance and framing errors.
// ----------------------------------------------------------------------------
// path: a byte passes through the input register, then the result register
// (the result register holds its byte while i_ready is low)
// throughput: one byte per cycle while the output is not stalled, set by the
// combinational counter update between the two registers
// reset: synchronous, clears all control state and restores default limits
// ----------------------------------------------------------------------------
module length_prefixed_request_deframer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lprd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lprd_pkg::FIELD_W-1:0]   i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_in_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [2:0]                     o_byte_role,
    output logic [7:0]                     o_out_byte,
    output logic [lprd_pkg::FIELD_W-1:0]   o_string_index,
    output logic                           o_string_done,
    output logic [1:0]                     o_frame_status
);
    import lprd_pkg::*;

    logic [FIELD_W-1:0] r_max_frame;
    logic [FIELD_W-1:0] r_max_count;

    logic               r_in_valid;
    logic [7:0]         r_in_byte;

    t_phase             r_phase,  n_phase;
    logic [1:0]         r_pos,    n_pos;
    logic [23:0]        r_asm,    n_asm;
    logic [FIELD_W-1:0] r_fbl,    n_fbl;
    logic [FIELD_W-1:0] r_sl,     n_sl;
    logic [FIELD_W-1:0] r_cur,    n_cur;
    logic [FIELD_W-1:0] r_dbl,    n_dbl;

    logic               r_out_valid;
    t_phase             r_role,   n_role;
    logic [7:0]         r_byte;
    logic [FIELD_W-1:0] r_idx,    n_idx;
    logic               r_done,   n_done;
    t_status            r_status, n_status;

    logic               advance;
    logic [FIELD_W-1:0] full;
    logic [FIELD_W-1:0] fbl_dec;
    logic [FIELD_W-1:0] dbl_dec;
    logic               last;
    logic               fbl_zero;

    assign advance  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready  = !r_in_valid || advance;
    assign full     = {r_in_byte, r_asm};
    assign last     = (r_pos == POS_LAST);
    assign fbl_dec  = r_fbl - 1'b1;
    assign dbl_dec  = r_dbl - 1'b1;
    assign fbl_zero = (fbl_dec == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame <= MAX_FRAME_BYTES_RST;
            r_max_count <= MAX_STRING_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_FRAME_BYTES:  r_max_frame <= i_cfg_data;
                CFG_MAX_STRING_COUNT: r_max_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_asm    = r_asm;
        n_fbl    = r_fbl;
        n_sl     = r_sl;
        n_cur    = r_cur;
        n_dbl    = r_dbl;
        n_role   = PH_CLOSED;
        n_idx    = '0;
        n_done   = 1'b0;
        n_status = ST_NONE;

        // field collection, shared by the frame length, count and string length phases
        if (r_phase == PH_FLEN || r_phase == PH_COUNT || r_phase == PH_SLEN) begin
            n_pos = r_pos + 1'b1;
            unique case (r_pos)
                2'd0:    n_asm = {16'd0, r_in_byte};
                2'd1:    n_asm[15:8]  = r_in_byte;
                2'd2:    n_asm[23:16] = r_in_byte;
                default: ;
            endcase
        end

        unique case (r_phase)
            PH_FLEN: begin
                n_role = PH_FLEN;
                if (last) begin
                    if (full > r_max_frame) begin
                        n_phase  = PH_CLOSED;
                        n_status = ST_TOO_LONG;
                    end else if (full == '0) begin
                        n_phase  = PH_CLOSED;
                        n_status = ST_BAD;
                    end else begin
                        n_fbl   = full;
                        n_phase = PH_COUNT;
                    end
                end
            end
            PH_COUNT: begin
                n_role = PH_COUNT;
                n_fbl  = fbl_dec;
                if (last) begin
                    if (full > r_max_count) begin
                        n_phase  = fbl_zero ? PH_CLOSED : PH_DISCARD;
                        n_status = fbl_zero ? ST_BAD : ST_NONE;
                    end else if (full == '0) begin
                        n_phase  = fbl_zero ? PH_FLEN : PH_DISCARD;
                        n_status = fbl_zero ? ST_ACCEPT : ST_NONE;
                    end else if (fbl_zero) begin
                        n_phase  = PH_CLOSED;
                        n_status = ST_BAD;
                    end else begin
                        n_sl    = full;
                        n_cur   = '0;
                        n_phase = PH_SLEN;
                    end
                end else if (fbl_zero) begin
                    n_phase  = PH_CLOSED;
                    n_status = ST_BAD;
                end
            end
            PH_SLEN, PH_DATA: begin
                n_role = r_phase;
                n_idx  = r_cur;
                n_fbl  = fbl_dec;
                if (r_phase == PH_DATA) begin
                    n_dbl = dbl_dec;
                end
                priority if ((r_phase == PH_SLEN && last && full == '0) ||
                             (r_phase == PH_DATA && dbl_dec == '0)) begin
                    // end of string
                    n_done = 1'b1;
                    n_sl   = r_sl - 1'b1;
                    n_cur  = r_cur + 1'b1;
                    if (r_sl == 32'd1) begin
                        n_phase  = fbl_zero ? PH_FLEN : PH_DISCARD;
                        n_status = fbl_zero ? ST_ACCEPT : ST_NONE;
                    end else if (fbl_zero) begin
                        n_phase  = PH_CLOSED;
                        n_status = ST_BAD;
                    end else begin
                        n_phase = PH_SLEN;
                        n_pos   = 2'd0;
                    end
                end else if (r_phase == PH_SLEN && last) begin
                    if (full > fbl_dec) begin
                        n_phase  = fbl_zero ? PH_CLOSED : PH_DISCARD;
                        n_status = fbl_zero ? ST_BAD : ST_NONE;
                    end else begin
                        n_dbl   = full;
                        n_phase = PH_DATA;
                    end
                end else if (r_phase == PH_SLEN && fbl_zero) begin
                    n_phase  = PH_CLOSED;
                    n_status = ST_BAD;
                end else begin
                end
            end
            PH_DISCARD: begin
                n_role = PH_DISCARD;
                n_fbl  = fbl_dec;
                if (fbl_zero) begin
                    n_phase  = PH_CLOSED;
                    n_status = ST_BAD;
                end
            end
            default: begin
                n_phase = PH_CLOSED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLEN;
            r_pos   <= 2'd0;
            r_asm   <= '0;
            r_fbl   <= '0;
            r_sl    <= '0;
            r_cur   <= '0;
            r_dbl   <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_asm   <= n_asm;
            r_fbl   <= n_fbl;
            r_sl    <= n_sl;
            r_cur   <= n_cur;
            r_dbl   <= n_dbl;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_role   <= n_role;
            r_byte   <= r_in_byte;
            r_idx    <= n_idx;
            r_done   <= n_done;
            r_status <= n_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_byte_role    = r_role;
    assign o_out_byte     = r_byte;
    assign o_string_index = r_idx;
    assign o_string_done  = r_done;
    assign o_frame_status = r_status;

    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_CLOSED |=> r_phase == PH_CLOSED)
        else $error("closed stream reopened");

    a_closed_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_role == PH_CLOSED |-> o_frame_status == ST_NONE)
        else $error("status reported on closed stream");

    a_done_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_string_done |-> (o_byte_role == PH_SLEN || o_byte_role == PH_DATA))
        else $error("string end outside string");

    a_too_long_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_status == ST_TOO_LONG |-> o_byte_role == PH_FLEN)
        else $error("too long flagged off frame length");

    a_index_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_string_index != '0 |->
            (o_byte_role == PH_SLEN || o_byte_role == PH_DATA))
        else $error("string index outside string");

endmodule
